>>> rtl/core/kvlp_pkg.sv
// Shared types, constants and helper functions of the key:value line parser.
package kvlp_pkg;

  localparam int unsigned LineNumBits = 16;
  localparam int unsigned LineOutBits = 16;
  localparam int unsigned CodeBits    = 8;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned ResDepth    = 4;
  localparam int unsigned ResPtrBits  = $clog2(ResDepth);
  localparam int unsigned ResCntBits  = $clog2(ResDepth) + 1;

  localparam logic [CodeBits-1:0] CharTab   = 8'h09;
  localparam logic [CodeBits-1:0] CharLf    = 8'h0A;
  localparam logic [CodeBits-1:0] CharCr    = 8'h0D;
  localparam logic [CodeBits-1:0] CharSpace = 8'h20;

  localparam logic [CodeBits-1:0] EscapeReset    = 8'h5C;
  localparam logic [CodeBits-1:0] CommentReset   = 8'h23;
  localparam logic [CodeBits-1:0] SeparatorReset = 8'h3A;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgEscape    = 2'd0,
    CfgComment   = 2'd1,
    CfgSeparator = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PhStart   = 2'd0,
    PhKey     = 2'd1,
    PhValue   = 2'd2,
    PhComment = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KindKey     = 2'd0,
    KindValue   = 2'd1,
    KindComment = 2'd2,
    KindStatus  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    StKv         = 3'd0,
    StComment    = 3'd1,
    StSpaced     = 3'd2,
    StNoKey      = 3'd3,
    StEmptyValue = 3'd4
  } status_e;

  typedef struct packed {
    logic [CodeBits-1:0] escape;
    logic [CodeBits-1:0] comment;
    logic [CodeBits-1:0] separator;
  } cfg_t;

  typedef struct packed {
    phase_e phase;
    logic   esc_pend;
    logic   seen_ns;
    logic   spaced;
    logic   key_has;
    logic   val_ns;
  } line_st_t;

  localparam line_st_t LineStClear = '{
    phase: PhStart, esc_pend: 1'b0, seen_ns: 1'b0, spaced: 1'b0,
    key_has: 1'b0, val_ns: 1'b0
  };

  typedef struct packed {
    kind_e                  kind;
    logic [CodeBits-1:0]    data;
    status_e                status;
    logic [LineOutBits-1:0] number;
    logic                   last;
  } res_t;

  // up to two words produced by one input word, in order
  typedef struct packed {
    logic [1:0] num;
    res_t       first;
    res_t       second;
  } res_pair_t;

  typedef struct packed {
    logic [ResCntBits-1:0] count;
    logic                  room2;
  } fifo_stat_t;

  function automatic logic is_blank(input logic [CodeBits-1:0] b);
    return (b == CharSpace) || ((b >= CharTab) && (b <= CharCr));
  endfunction

  function automatic status_e verdict(input line_st_t st, input cfg_t cfg);
    status_e s;
    if (st.spaced) begin
      s = StSpaced;
    end else if (st.phase == PhComment || !st.seen_ns) begin
      s = StComment;
    end else if (st.phase == PhKey && st.esc_pend && cfg.escape == cfg.separator) begin
      s = st.key_has ? StEmptyValue : StNoKey;
    end else if (st.phase != PhValue || !st.key_has) begin
      s = StNoKey;
    end else if (!st.val_ns) begin
      s = StEmptyValue;
    end else begin
      s = StKv;
    end
    return s;
  endfunction

endpackage

>>> rtl/core/kvlp_if.sv
// Valid/ready channel interfaces for text input and parsed result words.
interface kvlp_in_if import kvlp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CodeBits-1:0] text_byte;
  logic                end_of_content;

  modport source (output valid, output text_byte, output end_of_content, input ready);
  modport sink (input valid, input text_byte, input end_of_content, output ready);
endinterface

interface kvlp_out_if import kvlp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             item_kind;
  logic [CodeBits-1:0]    out_byte;
  logic [2:0]             line_status;
  logic [LineOutBits-1:0] line_number;
  logic                   last_of_item;

  modport source (
    output valid, output item_kind, output out_byte, output line_status,
    output line_number, output last_of_item, input ready
  );
  modport sink (
    input valid, input item_kind, input out_byte, input line_status,
    input line_number, input last_of_item, output ready
  );
endinterface

>>> rtl/core/kvlp_parse.sv
// Per-byte line state machine: classifies one byte and emits up to two result words.
module kvlp_parse import kvlp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [CodeBits-1:0] byte_i,
  input  logic                last_i,
  input  cfg_t                cfg_i,
  output res_pair_t           res_o
);

  line_st_t               st_q, st_d, tk, vst;
  logic                   prev_cr_q, prev_cr_d;
  logic [LineNumBits-1:0] cnt_q, cnt_d;
  logic                   tk_emit, close, emit;
  kind_e                  tk_kind;
  logic                   is_cr, is_lf, blank;
  res_t                   byte_w, stat_w;

  assign is_cr = (byte_i == CharCr);
  assign is_lf = (byte_i == CharLf);
  assign blank = is_blank(byte_i);

  // ordinary (non line-ending) byte
  always_comb begin
    tk      = st_q;
    tk_emit = 1'b0;
    tk_kind = KindKey;
    if (st_q.spaced || st_q.phase == PhComment) begin
      tk_emit = 1'b1;
      tk_kind = KindComment;
    end else if (!st_q.seen_ns && !blank && byte_i == cfg_i.comment) begin
      tk.seen_ns = 1'b1;
      tk_emit    = 1'b1;
      tk_kind    = KindComment;
      if (st_q.phase == PhStart) begin
        tk.phase = PhComment;
      end else begin
        tk.spaced = 1'b1;
      end
    end else begin
      if (!blank) begin
        tk.seen_ns = 1'b1;
      end
      if (st_q.phase == PhStart || st_q.phase == PhKey) begin
        tk.phase = PhKey;
        if (st_q.esc_pend) begin
          tk.esc_pend = 1'b0;
          tk.key_has  = 1'b1;
          tk_emit     = 1'b1;
        end else if (byte_i == cfg_i.escape) begin
          tk.esc_pend = 1'b1;
        end else if (byte_i == cfg_i.separator) begin
          tk.phase = PhValue;
        end else begin
          tk.key_has = 1'b1;
          tk_emit    = 1'b1;
        end
      end else begin
        if (!blank) begin
          tk.val_ns = 1'b1;
        end
        tk_emit = 1'b1;
        tk_kind = KindValue;
      end
    end
  end

  always_comb begin
    st_d      = st_q;
    prev_cr_d = prev_cr_q;
    cnt_d     = cnt_q;
    vst       = st_q;
    close     = 1'b0;
    emit      = 1'b0;
    if (prev_cr_q && is_lf) begin
      // LF after CR: pair already closed the line
      prev_cr_d = 1'b0;
    end else if (is_cr || is_lf) begin
      prev_cr_d = is_cr;
      close     = 1'b1;
    end else begin
      prev_cr_d = 1'b0;
      emit      = tk_emit;
      st_d      = tk;
      vst       = tk;
      close     = last_i;
    end
    if (close) begin
      st_d = LineStClear;
      if (cnt_q != {LineNumBits{1'b1}}) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
    if (last_i) begin
      st_d      = LineStClear;
      prev_cr_d = 1'b0;
      cnt_d     = LineNumBits'(1);
    end
  end

  always_comb begin
    byte_w        = '0;
    byte_w.kind   = tk_kind;
    byte_w.data   = byte_i;
    byte_w.status = StKv;
    byte_w.last   = !close;
    stat_w        = '0;
    stat_w.kind   = KindStatus;
    stat_w.status = verdict(vst, cfg_i);
    stat_w.number = LineOutBits'(cnt_q);
    stat_w.last   = 1'b1;
    res_o         = '0;
    res_o.num     = {1'b0, emit} + {1'b0, close};
    res_o.first   = emit ? byte_w : stat_w;
    res_o.second  = stat_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= LineStClear;
      prev_cr_q <= 1'b0;
      cnt_q     <= LineNumBits'(1);
    end else if (step_i) begin
      st_q      <= st_d;
      prev_cr_q <= prev_cr_d;
      cnt_q     <= cnt_d;
    end
  end

endmodule

>>> rtl/core/kvlp_res_fifo.sv
// Result queue: takes up to two words per cycle, hands out one per cycle while pop_i is high.
module kvlp_res_fifo import kvlp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  res_pair_t  push_i,
  input  logic       pop_i,
  output logic       valid_o,
  output res_t       head_o,
  output fifo_stat_t stat_o
);

  res_t                  mem_q [ResDepth];
  logic [ResPtrBits-1:0] wr_q, rd_q, wr1;
  logic [ResCntBits-1:0] cnt_q;
  logic                  pop;

  assign pop          = pop_i && (cnt_q != '0);
  assign wr1          = wr_q + 1'b1;
  assign valid_o      = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];
  assign stat_o.count = cnt_q;
  assign stat_o.room2 = (cnt_q <= ResCntBits'(ResDepth - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr1] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + ResPtrBits'(push_i.num);
      rd_q  <= rd_q + ResPtrBits'(pop);
      cnt_q <= cnt_q + ResCntBits'(push_i.num) - ResCntBits'(pop);
    end
  end

endmodule

>>> rtl/core/kv_config_line_parser_core.sv
// Top level of the streaming key:value configuration line parser.
//
//   channel   dir  handshake          word
//   text_i    in   valid/ready        text_byte, end_of_content
//   result_o  out  valid/ready        item_kind, out_byte, line_status,
//                                     line_number, last_of_item
//   cfg       in   cfg_we_i           cfg_idx_i selects register, cfg_data_i
//
// Path: a text word is held in the input register, is parsed in one pass,
//   and its 0..2 result words land in a 4-deep queue whose head drives
//   result_o.
// Rate: one text word per cycle while results are taken; a text byte flagged
//   end_of_content that is itself emitted yields two results and the
//   single-word queue read port then sets the pace.
// Stalls: the input register advances only while the queue has room for two
//   words; text_i.ready drops while a held word waits for that room.
// Reset: clears line state, sets the line counter to one, restores the escape,
//   comment and separator codes and empties the input register and the queue.
module kv_config_line_parser_core import kvlp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  kvlp_in_if.sink               text_i,
  kvlp_out_if.source            result_o,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [CodeBits-1:0]   cfg_data_i
);

  cfg_t                cfg_q;
  logic                in_vld_q, in_vld_d;
  logic [CodeBits-1:0] in_byte_q;
  logic                in_last_q;
  logic                fire, accept;
  res_pair_t           pair;
  res_pair_t           push;
  res_t                head;
  fifo_stat_t          fstat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.escape    <= EscapeReset;
      cfg_q.comment   <= CommentReset;
      cfg_q.separator <= SeparatorReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgEscape:    cfg_q.escape    <= cfg_data_i;
        CfgComment:   cfg_q.comment   <= cfg_data_i;
        CfgSeparator: cfg_q.separator <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // input register: parses when the queue can take a worst-case pair
  assign fire         = in_vld_q && fstat.room2;
  assign text_i.ready = !in_vld_q || fire;
  assign accept       = text_i.valid && text_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= text_i.text_byte;
      in_last_q <= text_i.end_of_content;
    end
  end

  kvlp_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .cfg_i  (cfg_q),
    .res_o  (pair)
  );

  // nothing enters the queue unless the parser actually steps
  always_comb begin
    push = pair;
    if (!fire) begin
      push.num = 2'd0;
    end
  end

  kvlp_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (result_o.ready),
    .valid_o (result_o.valid),
    .head_o  (head),
    .stat_o  (fstat)
  );

  assign result_o.item_kind    = head.kind;
  assign result_o.out_byte     = head.data;
  assign result_o.line_status  = head.status;
  assign result_o.line_number  = head.number;
  assign result_o.last_of_item = head.last;

  // queue never holds more than its depth
  a_fifo_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fstat.count <= ResCntBits'(ResDepth))
    else $error("result queue overflow");

  // a held input word waits until it is parsed
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !fire) |=> (in_vld_q && $stable(in_byte_q)))
    else $error("input word lost while stalled");

  // a two-word pair from the parser ends with a status word after a non-last byte word
  a_pair_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && pair.num == 2'd2) |-> (pair.second.kind == KindStatus && !pair.first.last))
    else $error("malformed result pair");

  // byte words carry no line number
  a_byte_no_num : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.item_kind != KindStatus) |-> (result_o.line_number == '0))
    else $error("byte word with line number");

endmodule
